>>> hw/rtl/scs_pkg.sv
// scs_pkg: shared types and constants for the scissor clip stack
// used by scs_push_calc and scissor_clip_stack_top
package scs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int WIDE_W      = 27;
  localparam int PADDR_W     = 4;

  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic [12:0] display_width;
    logic [12:0] display_height;
    logic [15:0] horizontal_scale;
  } cfg_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  localparam logic [1:0] REG_DISPLAY_WIDTH    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_HORIZONTAL_SCALE = 2'd2;

  localparam logic [12:0] RST_DISPLAY_WIDTH    = 13'd640;
  localparam logic [12:0] RST_DISPLAY_HEIGHT   = 13'd480;
  localparam logic [15:0] RST_HORIZONTAL_SCALE = 16'd256;

endpackage

>>> hw/rtl/scs_stack_ram.sv
// scs_stack_ram: generic single-port-write, registered-read memory
// holds the stack entries; no package dependency
module scs_stack_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 62
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/scs_push_calc.sv
// scs_push_calc: three-stage push arithmetic (scale, defaults and flip, intersect)
// depends on scs_pkg
module scs_push_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] size_w,
  input  logic signed [15:0] size_h,
  input  scs_pkg::cfg_t      cfg,
  input  scs_pkg::rect_t     top,
  input  logic               has_top,
  output logic               out_valid,
  output scs_pkg::rect_t     rect
);

  function automatic logic signed [15:0] sat_s16(input scs_pkg::wide_t v);
    logic signed [15:0] r;
    if (v > scs_pkg::wide_t'(32767)) r = 16'sh7fff;
    else if (v < scs_pkg::wide_t'(-32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [14:0] sat_u15(input scs_pkg::wide_t v);
    logic [14:0] r;
    if (v < scs_pkg::wide_t'(0)) r = 15'd0;
    else if (v > scs_pkg::wide_t'(32767)) r = 15'h7fff;
    else r = v[14:0];
    return r;
  endfunction

  // stage 1: products
  logic               s1_valid;
  logic signed [32:0] s1_px;
  logic signed [32:0] s1_pw;
  logic signed [15:0] s1_py;
  logic signed [15:0] s1_sh;
  logic signed [32:0] scale_ext;
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_w;

  assign scale_ext = $signed({17'd0, cfg.horizontal_scale});
  assign prod_x    = $signed({{17{pos_x[15]}}, pos_x}) * scale_ext;
  assign prod_w    = $signed({{17{size_w[15]}}, size_w}) * scale_ext;

  // stage 2: truncate toward zero, default sizes, y flip
  logic               s2_valid;
  scs_pkg::wide_t     s2_bx;
  scs_pkg::wide_t     s2_by;
  scs_pkg::wide_t     s2_bw;
  scs_pkg::wide_t     s2_bh;
  logic signed [32:0] adj_x;
  logic signed [32:0] adj_w;
  scs_pkg::wide_t     bx;
  scs_pkg::wide_t     bw_in;
  scs_pkg::wide_t     bw;
  scs_pkg::wide_t     bh;
  scs_pkg::wide_t     py;
  scs_pkg::wide_t     dw;
  scs_pkg::wide_t     dh;

  assign adj_x = s1_px + (s1_px[32] ? 33'sd255 : 33'sd0);
  assign adj_w = s1_pw + (s1_pw[32] ? 33'sd255 : 33'sd0);
  assign bx    = scs_pkg::wide_t'($signed(adj_x[32:8]));
  assign bw_in = scs_pkg::wide_t'($signed(adj_w[32:8]));
  assign py    = scs_pkg::wide_t'(s1_py);
  assign dw    = scs_pkg::wide_t'({1'b0, cfg.display_width});
  assign dh    = scs_pkg::wide_t'({1'b0, cfg.display_height});
  assign bw    = (bw_in == scs_pkg::wide_t'(0)) ? dw - bx : bw_in;
  assign bh    = (s1_sh == 16'sd0) ? dh - py : scs_pkg::wide_t'(s1_sh);

  // stage 3: intersect with the current top, clamp and saturate
  scs_pkg::wide_t tx;
  scs_pkg::wide_t ty;
  scs_pkg::wide_t tr;
  scs_pkg::wide_t tt;
  scs_pkg::wide_t nx;
  scs_pkg::wide_t ny;
  scs_pkg::wide_t cw;
  scs_pkg::wide_t ch;
  scs_pkg::wide_t nw;
  scs_pkg::wide_t nh;

  assign tx = scs_pkg::wide_t'(top.x);
  assign ty = scs_pkg::wide_t'(top.y);
  assign tr = tx + scs_pkg::wide_t'({1'b0, top.w});
  assign tt = ty + scs_pkg::wide_t'({1'b0, top.h});
  assign nx = (has_top && tx > s2_bx) ? tx : s2_bx;
  assign ny = (has_top && ty > s2_by) ? ty : s2_by;
  assign cw = tr - nx;
  assign ch = tt - ny;
  assign nw = (has_top && cw < s2_bw) ? cw : s2_bw;
  assign nh = (has_top && ch < s2_bh) ? ch : s2_bh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_px <= prod_x;
      s1_pw <= prod_w;
      s1_py <= pos_y;
      s1_sh <= size_h;
    end
    if (s1_valid) begin
      s2_bx <= bx;
      s2_bw <= bw;
      s2_bh <= bh;
      s2_by <= dh - py - bh;
    end
    if (s2_valid) begin
      rect.x <= sat_s16(nx);
      rect.y <= sat_s16(ny);
      rect.w <= sat_u15(nw);
      rect.h <= sat_u15(nh);
    end
  end

endmodule

>>> hw/rtl/scissor_clip_stack_top.sv
// scissor_clip_stack_top: scissor rectangle stack with config registers and control
// depends on scs_pkg, scs_stack_ram and scs_push_calc
//
//   channel   signals                                   transfer
//   config    psel penable pwrite paddr pwdata prdata   psel & penable & pwrite & pready
//   command   start busy cmd pos_x pos_y size_w size_h  start & !busy
//   result    done clip_x clip_y clip_w clip_h          done high for one cycle
//             clip_enable status
//
// push: done is registered once the three-stage push arithmetic delivers its result
// pop with two or more entries: done is registered in S_POP, after the ram read of the new top
// pop to empty, pop on empty, push on full: done in the cycle after the transfer
// top of stack lives in registers; every entry, the top included, is also written to a ram with registered read
// reset: stack empty, registers 640, 480, 256; results cannot be stalled
module scissor_clip_stack_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic signed [15:0]          pos_x,
  input  logic signed [15:0]          pos_y,
  input  logic signed [15:0]          size_w,
  input  logic signed [15:0]          size_h,
  output logic                        done,
  output logic signed [15:0]          clip_x,
  output logic signed [15:0]          clip_y,
  output logic [14:0]                 clip_w,
  output logic [14:0]                 clip_h,
  output logic                        clip_enable,
  output logic [1:0]                  status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_POP
  } state_t;

  state_t                state;
  scs_pkg::cfg_t         cfg;
  scs_pkg::cnt_t         count;
  scs_pkg::cnt_t         count_m2;
  scs_pkg::rect_t        top;
  scs_pkg::rect_t        calc_rect;
  scs_pkg::rect_t        rd_rect;
  logic [scs_pkg::RECT_W-1:0] rd_data;
  logic                  calc_valid;
  logic                  accept;
  logic                  full;
  logic                  calc_start;
  logic                  rd_en;
  logic                  wr_en;
  logic                  cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_width    <= scs_pkg::RST_DISPLAY_WIDTH;
      cfg.display_height   <= scs_pkg::RST_DISPLAY_HEIGHT;
      cfg.horizontal_scale <= scs_pkg::RST_HORIZONTAL_SCALE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        scs_pkg::REG_DISPLAY_WIDTH:    cfg.display_width    <= pwdata[12:0];
        scs_pkg::REG_DISPLAY_HEIGHT:   cfg.display_height   <= pwdata[12:0];
        scs_pkg::REG_HORIZONTAL_SCALE: cfg.horizontal_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      scs_pkg::REG_DISPLAY_WIDTH:    prdata = {19'd0, cfg.display_width};
      scs_pkg::REG_DISPLAY_HEIGHT:   prdata = {19'd0, cfg.display_height};
      scs_pkg::REG_HORIZONTAL_SCALE: prdata = {16'd0, cfg.horizontal_scale};
      default:                       prdata = 32'd0;
    endcase
  end

  // command control
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign full       = (count == scs_pkg::cnt_t'(scs_pkg::STACK_DEPTH));
  assign count_m2   = count - scs_pkg::cnt_t'(2);
  assign calc_start = accept && (cmd == scs_pkg::CMD_PUSH) && !full;
  assign rd_en      = accept && (cmd == scs_pkg::CMD_POP) && (count > scs_pkg::cnt_t'(1));
  assign wr_en      = (state == S_PUSH) && calc_valid;
  assign rd_rect    = scs_pkg::rect_t'(rd_data);

  scs_stack_ram #(
    .DEPTH (scs_pkg::STACK_DEPTH),
    .WIDTH (scs_pkg::RECT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[scs_pkg::ADDR_W-1:0]),
    .wr_data (calc_rect),
    .rd_en   (rd_en),
    .rd_addr (count_m2[scs_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  scs_push_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (calc_start),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .size_w    (size_w),
    .size_h    (size_h),
    .cfg       (cfg),
    .top       (top),
    .has_top   (count != scs_pkg::cnt_t'(0)),
    .out_valid (calc_valid),
    .rect      (calc_rect)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      status <= scs_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd == scs_pkg::CMD_PUSH) begin
              if (full) begin
                done        <= 1'b1;
                status      <= scs_pkg::ST_PUSH_FULL;
                clip_x      <= top.x;
                clip_y      <= top.y;
                clip_w      <= top.w;
                clip_h      <= top.h;
                clip_enable <= 1'b1;
              end else begin
                state <= S_PUSH;
              end
            end else if (count == scs_pkg::cnt_t'(0)) begin
              done        <= 1'b1;
              status      <= scs_pkg::ST_POP_EMPTY;
              clip_x      <= '0;
              clip_y      <= '0;
              clip_w      <= '0;
              clip_h      <= '0;
              clip_enable <= 1'b0;
            end else if (count == scs_pkg::cnt_t'(1)) begin
              count       <= '0;
              done        <= 1'b1;
              status      <= scs_pkg::ST_OK;
              clip_x      <= '0;
              clip_y      <= '0;
              clip_w      <= '0;
              clip_h      <= '0;
              clip_enable <= 1'b0;
            end else begin
              count <= count - scs_pkg::cnt_t'(1);
              state <= S_POP;
            end
          end
        end
        S_PUSH: begin
          if (calc_valid) begin
            top         <= calc_rect;
            count       <= count + scs_pkg::cnt_t'(1);
            done        <= 1'b1;
            status      <= scs_pkg::ST_OK;
            clip_x      <= calc_rect.x;
            clip_y      <= calc_rect.y;
            clip_w      <= calc_rect.w;
            clip_h      <= calc_rect.h;
            clip_enable <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_POP: begin
          top         <= rd_rect;
          done        <= 1'b1;
          status      <= scs_pkg::ST_OK;
          clip_x      <= rd_rect.x;
          clip_y      <= rd_rect.y;
          clip_w      <= rd_rect.w;
          clip_h      <= rd_rect.h;
          clip_enable <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= scs_pkg::cnt_t'(scs_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_enable_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (clip_enable == (count != scs_pkg::cnt_t'(0))))
    else $error("clip_enable disagrees with stack count");

  a_calc_only_in_push: assert property (@(posedge clk) disable iff (rst)
    calc_valid |-> (state == S_PUSH))
    else $error("push result outside push state");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == scs_pkg::ST_PUSH_FULL) |-> full)
    else $error("overflow status with room left");

  a_pop_read_follows_pop: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_POP))
    else $error("ram read without pop state");

endmodule
